// ===== hdl/sgd_pkg.sv =====
// types and constants for the sustained growth detector
// used by sustained_growth_detector and its testbench; no other dependencies

package sgd_pkg;

  localparam int NODE_W     = 4;
  localparam int SLOT_W     = 3;
  localparam int VALUE_W    = 32;
  localparam int MAG_W      = 33;
  localparam int RUN_W      = 8;
  localparam int RATIO_W    = 18;
  localparam int BUDGET_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int FRAC_W     = 16;

  localparam int MAX_RELEASE = 16;

  localparam logic [RATIO_W-1:0]  GROWTH_RATIO_RST   = 18'd68813;
  localparam logic [VALUE_W-1:0]  MIN_MAGNITUDE_RST  = 32'd0;
  localparam logic [RUN_W-1:0]    MIN_RUN_RST        = 8'd4;
  localparam logic [BUDGET_W-1:0] RECHECK_BUDGET_RST = 5'd1;

  typedef enum logic {
    OP_SAMPLE   = 1'b0,
    OP_END_STEP = 1'b1
  } op_t;

  typedef enum logic {
    KIND_REPORT  = 1'b0,
    KIND_RECHECK = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GROWTH_RATIO   = 2'd0,
    REG_MIN_MAGNITUDE  = 2'd1,
    REG_MIN_RUN        = 2'd2,
    REG_RECHECK_BUDGET = 2'd3
  } cfg_reg_t;

  // per-slot history kept in the slot memory
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [MAG_W-1:0]   magnitude;
    logic [RUN_W-1:0]   run;
    logic               episode;
  } slot_entry_t;

endpackage

// ===== hdl/sustained_growth_detector.sv =====
// sustained growth detector: slot history memory, growth test, re-check queue
// depends on sgd_pkg

// A sample item is accepted into a stage register while its slot entry is read
// from the slot memory; from the stage register the step magnitude, the ratio
// multiply-compare and the run update are done and the entry is written back
// (a back-to-back sample of the same slot is forwarded). Samples stream at one
// per cycle while results are taken. An end-of-step item holds the stage while
// it releases re-check requests (at most min(recheck_budget, 16), one result
// per cycle while results are taken). Results leave through an output register;
// a held output only stalls items that produce a result. After reset the slot
// history reads as zero at once through a valid bit per slot; there is no
// clearing pass.
module sustained_growth_detector #(
  parameter int MAX_NODES      = 16,
  parameter int SLOTS_PER_NODE = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // input items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                operation,
  input  logic [sgd_pkg::NODE_W-1:0]          node_index,
  input  logic [sgd_pkg::SLOT_W-1:0]          slot_index,
  input  logic signed [sgd_pkg::VALUE_W-1:0]  sample_value,
  input  logic                                node_done,
  // results
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                kind,
  output logic [sgd_pkg::NODE_W-1:0]          out_node,
  output logic [sgd_pkg::SLOT_W-1:0]          out_slot,
  output logic [sgd_pkg::RUN_W-1:0]           run_length,
  output logic                                last,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sgd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sgd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // only ids that fit the port fields can ever be addressed
  localparam int NODE_CNT = (MAX_NODES > 2**sgd_pkg::NODE_W) ? 2**sgd_pkg::NODE_W : MAX_NODES;
  localparam int SLOT_CNT = (SLOTS_PER_NODE > 2**sgd_pkg::SLOT_W) ?
                            2**sgd_pkg::SLOT_W : SLOTS_PER_NODE;
  localparam int DEPTH    = NODE_CNT * SLOT_CNT;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW       = (NODE_CNT > 1) ? $clog2(NODE_CNT) : 1;
  localparam int CW       = $clog2(NODE_CNT + 1);
  localparam int PROD_W   = sgd_pkg::RATIO_W + sgd_pkg::MAG_W;

  // configuration registers
  logic [sgd_pkg::RATIO_W-1:0]  growth_ratio;
  logic [sgd_pkg::VALUE_W-1:0]  min_magnitude;
  logic [sgd_pkg::RUN_W-1:0]    min_run;
  logic [sgd_pkg::BUDGET_W-1:0] recheck_budget;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      growth_ratio   <= sgd_pkg::GROWTH_RATIO_RST;
      min_magnitude  <= sgd_pkg::MIN_MAGNITUDE_RST;
      min_run        <= sgd_pkg::MIN_RUN_RST;
      recheck_budget <= sgd_pkg::RECHECK_BUDGET_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sgd_pkg::REG_GROWTH_RATIO:   growth_ratio   <= cfg_data[sgd_pkg::RATIO_W-1:0];
        sgd_pkg::REG_MIN_MAGNITUDE:  min_magnitude  <= cfg_data[sgd_pkg::VALUE_W-1:0];
        sgd_pkg::REG_MIN_RUN:        min_run        <= cfg_data[sgd_pkg::RUN_W-1:0];
        sgd_pkg::REG_RECHECK_BUDGET: recheck_budget <= cfg_data[sgd_pkg::BUDGET_W-1:0];
        default: ;
      endcase
    end
  end

  // input side
  logic    accept;
  logic    in_range;
  logic [AW-1:0] in_addr;

  assign accept   = in_valid && !in_stall;
  assign in_range = (32'(node_index) < NODE_CNT) && (32'(slot_index) < SLOT_CNT);
  assign in_addr  = in_range ? AW'(32'(node_index) * SLOT_CNT + 32'(slot_index)) : '0;

  // work stage
  logic                              s1_valid;
  sgd_pkg::op_t                      s1_op;
  logic                              s1_in_range;
  logic [AW-1:0]                     s1_addr;
  logic [sgd_pkg::NODE_W-1:0]        s1_node;
  logic [sgd_pkg::SLOT_W-1:0]        s1_slot;
  logic [sgd_pkg::VALUE_W-1:0]       s1_value;
  logic                              s1_done;
  logic [sgd_pkg::BUDGET_W-1:0]      released;
  logic [sgd_pkg::BUDGET_W-1:0]      released_next;

  // slot memory and its bypass
  sgd_pkg::slot_entry_t slot_mem [DEPTH];
  sgd_pkg::slot_entry_t rd_entry;
  sgd_pkg::slot_entry_t fwd_entry;
  sgd_pkg::slot_entry_t wr_entry;
  logic                 fwd_hit;
  logic [DEPTH-1:0]     seen;
  logic                 wr_en;

  // re-check queue
  logic [sgd_pkg::NODE_W-1:0] fifo_mem [NODE_CNT];
  logic [NW-1:0]              head;
  logic [CW-1:0]              count;
  logic [NODE_CNT-1:0]        queued;
  logic                       crossed;

  // datapath
  sgd_pkg::slot_entry_t          cur;
  logic                          cur_seen;
  logic signed [sgd_pkg::MAG_W-1:0] diff;
  logic [sgd_pkg::MAG_W-1:0]     mag;
  logic [PROD_W-1:0]             prod;
  logic [PROD_W-1:0]             mag_scaled;
  logic                          check;
  logic                          grow;
  logic [sgd_pkg::RUN_W-1:0]     run_n;
  logic                          ep_n;
  logic                          report;
  logic                          crossed_after;
  logic [sgd_pkg::BUDGET_W-1:0]  budget_eff;
  logic                          drain_go;
  logic                          drain_last;
  logic                          emit_req;
  logic                          emit;
  logic                          out_free;
  logic                          s1_finish;
  logic                          pop;
  logic                          push;
  logic [NW:0]                   tail_sum;
  logic [NW-1:0]                 tail;
  logic [NW-1:0]                 head_next;
  logic [NW-1:0]                 s1_node_idx;

  assign s1_node_idx = s1_node[NW-1:0];

  always_comb begin
    // an entry never written reads as zero
    cur_seen = seen[s1_addr];
    cur      = fwd_hit ? fwd_entry : rd_entry;
    if (!cur_seen) begin
      cur = '0;
    end

    diff = $signed({s1_value[sgd_pkg::VALUE_W-1], s1_value}) -
           $signed({cur.value[sgd_pkg::VALUE_W-1], cur.value});
    mag  = diff[sgd_pkg::MAG_W-1] ? sgd_pkg::MAG_W'(-diff) : sgd_pkg::MAG_W'(diff);

    prod       = PROD_W'(growth_ratio) * PROD_W'(cur.magnitude);
    mag_scaled = PROD_W'({mag, {sgd_pkg::FRAC_W{1'b0}}});
    check      = cur_seen && (cur.magnitude > {1'b0, min_magnitude});
    grow       = mag_scaled > prod;

    run_n = cur.run;
    ep_n  = cur.episode;
    if (check) begin
      if (grow) begin
        if (cur.run != {sgd_pkg::RUN_W{1'b1}}) begin
          run_n = cur.run + 1'b1;
        end
      end else begin
        run_n = '0;
        ep_n  = 1'b0;
      end
    end

    report        = s1_valid && (s1_op == sgd_pkg::OP_SAMPLE) && s1_in_range &&
                    (run_n >= min_run) && !ep_n;
    crossed_after = crossed || report;

    wr_entry.value     = s1_value;
    wr_entry.magnitude = mag;
    wr_entry.run       = run_n;
    wr_entry.episode   = ep_n || report;

    budget_eff = (recheck_budget > sgd_pkg::BUDGET_W'(sgd_pkg::MAX_RELEASE)) ?
                 sgd_pkg::BUDGET_W'(sgd_pkg::MAX_RELEASE) : recheck_budget;
    drain_go   = s1_valid && (s1_op == sgd_pkg::OP_END_STEP) && (count != '0) &&
                 (released < budget_eff);
    drain_last = ((released + 1'b1) == budget_eff) || (count == CW'(1));

    out_free  = !out_valid || !out_stall;
    emit_req  = report || drain_go;
    emit      = emit_req && out_free;
    s1_finish = s1_valid && (!emit_req ||
                (emit && ((s1_op == sgd_pkg::OP_SAMPLE) || drain_last)));

    wr_en = s1_valid && (s1_op == sgd_pkg::OP_SAMPLE) && s1_in_range && s1_finish;
    pop   = drain_go && emit;
    push  = wr_en && s1_done && crossed_after && !queued[s1_node_idx] &&
            (count < CW'(NODE_CNT));

    released_next = pop ? released + 1'b1 : released;

    tail_sum  = (NW + 1)'(head) + (NW + 1)'(count);
    tail      = (tail_sum >= (NW + 1)'(NODE_CNT)) ?
                NW'(tail_sum - (NW + 1)'(NODE_CNT)) : NW'(tail_sum);
    head_next = (head == NW'(NODE_CNT - 1)) ? '0 : head + 1'b1;
  end

  assign in_stall = s1_valid && !s1_finish;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        // the entry written at this edge is not yet in the read data
        fwd_hit  <= wr_en && (s1_addr == in_addr);
      end else if (s1_finish) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op       <= sgd_pkg::op_t'(operation);
      s1_in_range <= in_range;
      s1_addr     <= in_addr;
      s1_node     <= node_index;
      s1_slot     <= slot_index;
      s1_value    <= sample_value;
      s1_done     <= node_done;
      fwd_entry   <= wr_entry;
      released    <= '0;
    end else begin
      released    <= released_next;
    end
  end

  // slot memory: read on transfer, write when a sample completes
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_entry <= slot_mem[in_addr];
    end
    if (wr_en) begin
      slot_mem[s1_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen    <= '0;
      crossed <= 1'b0;
    end else if (wr_en) begin
      seen[s1_addr] <= 1'b1;
      crossed       <= s1_done ? 1'b0 : crossed_after;
    end
  end

  // re-check queue
  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      count  <= '0;
      queued <= '0;
    end else begin
      if (pop) begin
        head  <= head_next;
        count <= count - 1'b1;
        queued[fifo_mem[head][NW-1:0]] <= 1'b0;
      end else if (push) begin
        count <= count + 1'b1;
        queued[s1_node_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[tail] <= s1_node;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (report) begin
        kind       <= sgd_pkg::KIND_REPORT;
        out_node   <= s1_node;
        out_slot   <= s1_slot;
        run_length <= run_n;
        last       <= 1'b1;
      end else begin
        kind       <= sgd_pkg::KIND_RECHECK;
        out_node   <= fifo_mem[head];
        out_slot   <= '0;
        run_length <= '0;
        last       <= drain_last;
      end
    end
  end

endmodule

// ===== tb/tb_sustained_growth_detector.sv =====
// self-checking testbench for sustained_growth_detector: growth reports and re-check releases
// depends on sgd_pkg and the sustained_growth_detector rtl; nothing else

module tb_sustained_growth_detector;

  localparam int NODES = 16;
  localparam int SLOTS = 8;

  typedef struct {
    sgd_pkg::kind_t                kind;
    logic [sgd_pkg::NODE_W-1:0]    node;
    logic [sgd_pkg::SLOT_W-1:0]    slot;
    logic [sgd_pkg::RUN_W-1:0]     run;
    logic                          last;
  } finding_t;

  // keeps its own copy of slot history and re-check queue, predicts every result
  class growth_tracker;
    logic [sgd_pkg::RATIO_W-1:0]  ratio;
    logic [sgd_pkg::VALUE_W-1:0]  min_mag;
    logic [sgd_pkg::RUN_W-1:0]    min_run;
    logic [sgd_pkg::BUDGET_W-1:0] budget;

    logic [sgd_pkg::VALUE_W-1:0] last_value[NODES*SLOTS];
    logic [sgd_pkg::MAG_W-1:0]   last_mag[NODES*SLOTS];
    bit                          mag_valid[NODES*SLOTS];
    logic [sgd_pkg::RUN_W-1:0]   run_count[NODES*SLOTS];
    bit                          reported[NODES*SLOTS];
    bit                          crossed;
    bit                          in_queue[NODES];
    logic [sgd_pkg::NODE_W-1:0]  recheck_q[$];

    finding_t pending[$];
    int       errors;

    function new();
      ratio   = sgd_pkg::GROWTH_RATIO_RST;
      min_mag = sgd_pkg::MIN_MAGNITUDE_RST;
      min_run = sgd_pkg::MIN_RUN_RST;
      budget  = sgd_pkg::RECHECK_BUDGET_RST;
      foreach (last_value[i]) begin
        last_value[i] = '0;
        last_mag[i]   = '0;
        mag_valid[i]  = 0;
        run_count[i]  = '0;
        reported[i]   = 0;
      end
      foreach (in_queue[i]) in_queue[i] = 0;
      crossed = 0;
      errors  = 0;
    endfunction

    function void write_reg(sgd_pkg::cfg_reg_t idx, logic [sgd_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        sgd_pkg::REG_GROWTH_RATIO:   ratio   = data[sgd_pkg::RATIO_W-1:0];
        sgd_pkg::REG_MIN_MAGNITUDE:  min_mag = data[sgd_pkg::VALUE_W-1:0];
        sgd_pkg::REG_MIN_RUN:        min_run = data[sgd_pkg::RUN_W-1:0];
        sgd_pkg::REG_RECHECK_BUDGET: budget  = data[sgd_pkg::BUDGET_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(sgd_pkg::op_t op, logic [sgd_pkg::NODE_W-1:0] node,
                            logic [sgd_pkg::SLOT_W-1:0] slot,
                            logic [sgd_pkg::VALUE_W-1:0] value, logic done);
      int                        s;
      int                        cap;
      int                        released;
      longint                    delta;
      logic [sgd_pkg::MAG_W-1:0] mag;
      logic [63:0]               scaled;
      logic [63:0]               bound;
      finding_t                  f;
      if (op == sgd_pkg::OP_END_STEP) begin
        cap = (budget > sgd_pkg::MAX_RELEASE) ? sgd_pkg::MAX_RELEASE : int'(budget);
        released = 0;
        while (released < cap && recheck_q.size() != 0) begin
          f.kind = sgd_pkg::KIND_RECHECK;
          f.node = recheck_q.pop_front();
          f.slot = '0;
          f.run  = '0;
          released++;
          f.last = (released == cap) || (recheck_q.size() == 0);
          in_queue[f.node] = 0;
          pending.insert(pending.size(), f);
        end
        return;
      end
      s = int'(node) * SLOTS + int'(slot);
      delta = longint'($signed(value)) - longint'($signed(last_value[s]));
      mag = (delta < 0) ? sgd_pkg::MAG_W'(-delta) : sgd_pkg::MAG_W'(delta);
      // growth test only once a previous step exists and is big enough
      if (mag_valid[s] && last_mag[s] > {1'b0, min_mag}) begin
        scaled = 64'(mag) << sgd_pkg::FRAC_W;
        bound  = 64'(ratio) * 64'(last_mag[s]);
        if (scaled > bound) begin
          if (run_count[s] != 8'hFF) run_count[s]++;
        end else begin
          run_count[s] = '0;
          reported[s]  = 0;
        end
      end
      last_value[s] = value;
      last_mag[s]   = mag;
      mag_valid[s]  = 1;
      if (run_count[s] >= min_run && !reported[s]) begin
        reported[s] = 1;
        crossed     = 1;
        f.kind = sgd_pkg::KIND_REPORT;
        f.node = node;
        f.slot = slot;
        f.run  = run_count[s];
        f.last = 1'b1;
        pending.insert(pending.size(), f);
      end
      // single crossed bit: whichever node closes next gets queued
      if (done) begin
        if (crossed && !in_queue[node] && recheck_q.size() < NODES) begin
          recheck_q.insert(recheck_q.size(), node);
          in_queue[node] = 1;
        end
        crossed = 0;
      end
    endfunction

    function void check_finding(sgd_pkg::kind_t k, logic [sgd_pkg::NODE_W-1:0] node,
                                logic [sgd_pkg::SLOT_W-1:0] slot,
                                logic [sgd_pkg::RUN_W-1:0] run, logic last_flag);
      finding_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: kind %0d node %0d slot %0d run %0d last %0d",
                   k, node, slot, run, last_flag);
        return;
      end
      e = pending.pop_front();
      if (k !== e.kind || node !== e.node || slot !== e.slot || run !== e.run ||
          last_flag !== e.last) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: expected kind %0d node %0d slot %0d run %0d last %0d, ",
                    "got %0d %0d %0d %0d %0d"},
                   e.kind, e.node, e.slot, e.run, e.last, k, node, slot, run, last_flag);
      end
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic                              operation = 1'b0;
  logic [sgd_pkg::NODE_W-1:0]        node_index = '0;
  logic [sgd_pkg::SLOT_W-1:0]        slot_index = '0;
  logic [sgd_pkg::VALUE_W-1:0]       sample_value = '0;
  logic                              node_done = 1'b0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic                              kind;
  logic [sgd_pkg::NODE_W-1:0]        out_node;
  logic [sgd_pkg::SLOT_W-1:0]        out_slot;
  logic [sgd_pkg::RUN_W-1:0]         run_length;
  logic                              last;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [sgd_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [sgd_pkg::CFG_DATA_W-1:0]    cfg_data = '0;

  growth_tracker sb;

  // stimulus-side view of each slot, used to build growing sequences
  longint trace_value[NODES*SLOTS];
  longint trace_step[NODES*SLOTS];

  bit driving = 0;
  int burst_left = 4;
  int stall_mode = 0;
  int stall_tick = 0;
  int stall_hold = 0;
  int items = 0;

  sustained_growth_detector #(.MAX_NODES(NODES), .SLOTS_PER_NODE(SLOTS)) uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: switches between no stall, scattered stalls and stall bursts
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 64 == 63) stall_mode <= int'($urandom_range(0, 2));
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: begin
        if (stall_hold != 0) begin
          out_stall <= 1'b1;
          stall_hold <= stall_hold - 1;
        end else if ($urandom_range(0, 7) == 0) begin
          out_stall <= 1'b1;
          stall_hold <= int'($urandom_range(0, 5));
        end else begin
          out_stall <= 1'b0;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall)
      sb.check_finding(sgd_pkg::kind_t'(kind), out_node, out_slot, run_length, last);
  end

  task automatic send_item(sgd_pkg::op_t op, logic [sgd_pkg::NODE_W-1:0] node,
                           logic [sgd_pkg::SLOT_W-1:0] slot,
                           logic [sgd_pkg::VALUE_W-1:0] value, logic done);
    if (!driving) begin
      in_valid <= 1'b1;
      driving = 1;
    end
    operation    <= op;
    node_index   <= node;
    slot_index   <= slot;
    sample_value <= value;
    node_done    <= done;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_item(op, node, slot, value, done);
    if (op == sgd_pkg::OP_SAMPLE)
      trace_value[int'(node) * SLOTS + int'(slot)] = longint'($signed(value));
    items++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      driving = 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(30, 80)) :
                                                  int'($urandom_range(1, 12));
    end
  endtask

  task automatic send_sample(logic [sgd_pkg::NODE_W-1:0] node,
                             logic [sgd_pkg::SLOT_W-1:0] slot,
                             logic [sgd_pkg::VALUE_W-1:0] value, logic done);
    send_item(sgd_pkg::OP_SAMPLE, node, slot, value, done);
  endtask

  // ignored fields of an end-of-step transfer carry random bits
  task automatic send_end_step();
    send_item(sgd_pkg::OP_END_STEP, sgd_pkg::NODE_W'($urandom_range(0, NODES-1)),
              sgd_pkg::SLOT_W'($urandom_range(0, SLOTS-1)), $urandom,
              1'($urandom_range(0, 1)));
  endtask

  task automatic settle();
    if (driving) begin
      in_valid <= 1'b0;
      driving = 0;
    end
    while (sb.pending.size() != 0) @(posedge clk);
    // end-of-step with nothing to release still occupies the stage a while
    repeat (24) @(posedge clk);
  endtask

  task automatic configure(logic [sgd_pkg::RATIO_W-1:0] ratio,
                           logic [sgd_pkg::VALUE_W-1:0] min_mag,
                           logic [sgd_pkg::RUN_W-1:0] min_run,
                           logic [sgd_pkg::BUDGET_W-1:0] budget);
    sgd_pkg::cfg_reg_t              idx;
    logic [sgd_pkg::CFG_DATA_W-1:0] data;
    cfg_valid <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      idx = sgd_pkg::cfg_reg_t'(i);
      case (idx)
        sgd_pkg::REG_GROWTH_RATIO:  data = sgd_pkg::CFG_DATA_W'(ratio);
        sgd_pkg::REG_MIN_MAGNITUDE: data = min_mag;
        sgd_pkg::REG_MIN_RUN:       data = sgd_pkg::CFG_DATA_W'(min_run);
        default:                    data = sgd_pkg::CFG_DATA_W'(budget);
      endcase
      cfg_index <= idx;
      cfg_data  <= data;
      do @(posedge clk); while (cfg_ready !== 1'b1);
      sb.write_reg(idx, data);
    end
    cfg_valid <= 1'b0;
  endtask

  // next value of a slot: mostly a step just above ratio times the last one
  function automatic logic [sgd_pkg::VALUE_W-1:0] grow_value(int s);
    longint st;
    longint v;
    st = trace_step[s];
    if (st == 0 || st > 64'd134217728 || $urandom_range(0, 9) == 0)
      st = longint'($urandom_range(1, 2000));
    else
      st = ((st * longint'(sb.ratio)) >>> sgd_pkg::FRAC_W) + 1 +
           longint'($urandom_range(0, 3));
    trace_step[s] = st;
    v = trace_value[s];
    if (v > 64'sd1073741824) v = v - st;
    else if (v < -64'sd1073741824) v = v + st;
    else if ($urandom_range(0, 1) == 0) v = v - st;
    else v = v + st;
    return v[sgd_pkg::VALUE_W-1:0];
  endfunction

  task automatic node_pass(int base);
    logic [sgd_pkg::NODE_W-1:0] node;
    int                         nslots;
    bit                         close_node;
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 6) != 0)
        node = sgd_pkg::NODE_W'(base + int'($urandom_range(0, 3)));
      else
        node = sgd_pkg::NODE_W'($urandom_range(0, NODES-1));
      nslots = int'($urandom_range(1, SLOTS));
      close_node = ($urandom_range(0, 9) != 0);
      for (int k = 0; k < nslots; k++)
        send_sample(node, sgd_pkg::SLOT_W'(k), grow_value(int'(node) * SLOTS + k),
                    close_node && k == nslots-1);
    end
    if ($urandom_range(0, 6) != 0) send_end_step();
  endtask

  task automatic random_phase(int count);
    int target;
    int base;
    target = items + count;
    base = int'($urandom_range(0, NODES-1));
    while (items < target) begin
      if ($urandom_range(0, 3) != 0) begin
        node_pass(base);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 5) == 0) send_end_step();
          else send_sample(sgd_pkg::NODE_W'($urandom_range(0, NODES-1)),
                           sgd_pkg::SLOT_W'($urandom_range(0, SLOTS-1)), $urandom,
                           1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin
    int     ladder[5];
    longint v;
    longint dir;
    ladder = '{100, 300, 700, 1500, 3100};
    sb = new();
    foreach (trace_value[i]) begin
      trace_value[i] = 0;
      trace_step[i]  = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: empty release, extreme values, two full episodes, two releases
    send_end_step();
    send_sample(4'd0, 3'd0, 32'h7FFF_FFFF, 1'b1);
    send_sample(4'd15, 3'd7, 32'h8000_0000, 1'b1);
    send_sample(4'd15, 3'd7, 32'h7FFF_FFFF, 1'b1);
    send_sample(4'd0, 3'd0, 32'h8000_0000, 1'b1);
    foreach (ladder[k]) send_sample(4'd3, 3'd2, sgd_pkg::VALUE_W'(ladder[k]), k == 4);
    foreach (ladder[k]) send_sample(4'd5, 3'd1, sgd_pkg::VALUE_W'(-ladder[k]), k == 4);
    send_end_step();
    send_end_step();
    send_sample(4'd3, 3'd2, 32'd3100, 1'b1);
    send_end_step();

    settle();
    configure(18'd65536, 32'd0, 8'd1, 5'd16);
    random_phase(16);
    settle();
    configure(18'd262143, 32'd0, 8'd2, 5'd31);
    random_phase(16);
    settle();
    // min run of zero, unreachable magnitude floor, zero budget
    configure(18'd68813, 32'hFFFF_FFFF, 8'd0, 5'd0);
    random_phase(12);
    settle();
    configure(18'd100000, 32'd50, 8'd3, 5'd2);
    random_phase(12);
    settle();
    // one slot grows past run 255 so the counter saturates
    configure(18'd65536, 32'd0, 8'd255, 5'd5);
    v = trace_value[9*SLOTS + 4];
    dir = (v > 0) ? -1 : 1;
    for (int k = 0; k < 260; k++) begin
      v = v + dir * k;
      send_sample(4'd9, 3'd4, v[sgd_pkg::VALUE_W-1:0], k == 259);
    end
    send_end_step();
    random_phase(4);
    settle();
    configure(sgd_pkg::RATIO_W'($urandom_range(65536, 262143)),
              sgd_pkg::VALUE_W'($urandom_range(0, 400)),
              sgd_pkg::RUN_W'($urandom_range(1, 6)),
              sgd_pkg::BUDGET_W'($urandom_range(0, 16)));
    random_phase(16);
    settle();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (sb.pending.size() != 0)
        $display("%0d expected results never arrived", sb.pending.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
